// ===== hdl/tlb_page_table_translator_defines.svh =====
// Assertion macros shared by the translator RTL.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH

// expr must hold in the same cycle as cond
`define TLBPT_ASSERT_HOLDS(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// expr must hold in the cycle after cond
`define TLBPT_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== hdl/tlbpt_pkg.sv =====
package tlbpt_pkg;

   localparam int VA_W = 16;
   localparam int PA_W = 16;

   localparam int DEF_TLB_ENTRIES  = 16;
   localparam int DEF_PAGE_COUNT   = 256;
   localparam int DEF_OFFSET_WIDTH = 8;

   // fixed-point scale of the page-number reciprocal
   localparam int RECIP_SHIFT = 24;

   typedef struct packed {
      logic [VA_W-1:0] virtual_address;
   } req_payload_type;

   typedef struct packed {
      logic [PA_W-1:0] phys_addr;
      logic            tlb_hit;
      logic            page_fault;
   } rsp_payload_type;

   typedef struct packed {
      logic shift;
      logic capture;
   } cell_ctrl_type;

endpackage

// ===== hdl/tlbpt_stream_if.sv =====
interface tlbpt_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

// ===== hdl/tlbpt_ram.sv =====
module tlbpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tlbpt_cell.sv =====
module tlbpt_cell import tlbpt_pkg::*; #(
   parameter int PAGE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic [PAGE_W-1:0] lookup_page,
   input  logic [PAGE_W-1:0] in_tag,
   input  logic [PAGE_W-1:0] in_frame,
   input  logic              in_valid,
   output logic [PAGE_W-1:0] out_tag,
   output logic [PAGE_W-1:0] out_frame,
   output logic              out_valid,
   output logic              match,
   output logic [PAGE_W-1:0] match_frame
);

   logic [PAGE_W-1:0] tag_ff;
   logic [PAGE_W-1:0] frame_ff;
   logic              valid_ff;
   logic              match_ff;
   logic              match_in;
   logic [PAGE_W-1:0] match_frame_ff;

   assign match_in = valid_ff && (tag_ff == lookup_page);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         if (ctrl.shift) begin
            valid_ff <= in_valid;
         end
         if (ctrl.capture) begin
            match_ff <= match_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         tag_ff   <= in_tag;
         frame_ff <= in_frame;
      end
      // masked so the row can be OR-reduced
      if (ctrl.capture) begin
         match_frame_ff <= match_in ? frame_ff : '0;
      end
   end

   assign out_tag     = tag_ff;
   assign out_frame   = frame_ff;
   assign out_valid   = valid_ff;
   assign match       = match_ff;
   assign match_frame = match_frame_ff;

endmodule

// ===== hdl/tlbpt_reduce.sv =====
// Page number modulo PAGE_COUNT by reciprocal multiply and one correction.
module tlbpt_reduce import tlbpt_pkg::*; #(
   parameter int RAW_W      = 9,
   parameter int PAGE_COUNT = 256
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic [RAW_W-1:0]              raw_page,
   input  logic                          advance,
   output logic [$clog2(PAGE_COUNT)-1:0] page
);

   localparam int PG_W    = $clog2(PAGE_COUNT);
   localparam int RECIP   = (1 << RECIP_SHIFT) / PAGE_COUNT;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W  = RAW_W + RECIP_W;
   localparam int MOD_W   = RAW_W + PG_W + 1;

   logic [RAW_W-1:0]  raw_ff;
   logic [PROD_W-1:0] product_ff;
   logic [PROD_W-1:0] product_in;
   logic [RAW_W-1:0]  quot;
   logic [MOD_W-1:0]  quot_mul;
   logic [MOD_W-1:0]  rem;
   logic [PG_W-1:0]   page_ff;
   logic [PG_W-1:0]   page_in;

   assign product_in = PROD_W'(raw_page) * PROD_W'(RECIP);

   // quotient estimate is exact or one short, so rem < 2 * PAGE_COUNT
   assign quot     = RAW_W'(product_ff >> RECIP_SHIFT);
   assign quot_mul = MOD_W'(quot) * MOD_W'(PAGE_COUNT);
   assign rem      = MOD_W'(raw_ff) - quot_mul;
   assign page_in  = (rem >= MOD_W'(PAGE_COUNT)) ? PG_W'(rem - MOD_W'(PAGE_COUNT))
                                                 : PG_W'(rem);

   always_ff @(posedge clock) begin
      if (load) begin
         raw_ff     <= raw_page;
         product_ff <= product_in;
      end
      if (advance) begin
         page_ff <= page_in;
      end
   end

   assign page = page_ff;

endmodule

// ===== hdl/tlb_page_table_translator.sv =====
// TLB and page-table address translator.
// req_channel carries one 16-bit virtual address per request; rsp_channel returns
// the physical address with a TLB-hit flag and a page-fault flag, one per request,
// in order. Both are valid/ready channels; a request moves when both are high.
// The TLB is a row of cells: a miss pushes the new page/frame pair into the first
// cell and every entry moves one cell along, the oldest dropping off the end.
// Each request runs through the sequencer in order: page reduction (reciprocal
// multiply), cell compare plus page-table read, then resolve/fill. The response
// register is loaded at resolve; a new request is taken only after the last
// one has resolved and been committed to the response register.
// After reset the page table is swept invalid, one entry per cycle, over all
// PAGE_COUNT entries; req ready stays low until the sweep is done. Reset empties
// the TLB and restarts frame allocation at zero.
// A response waiting on a stalled receiver does not block the next request; a
// finished lookup holds in its last stage until the response register frees.
`include "tlb_page_table_translator_defines.svh"

module tlb_page_table_translator import tlbpt_pkg::*; #(
   parameter int TLB_ENTRIES  = DEF_TLB_ENTRIES,
   parameter int PAGE_COUNT   = DEF_PAGE_COUNT,
   parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH
) (
   input  logic           clock,
   input  logic           reset,
   tlbpt_stream_if.sink   req_channel,
   tlbpt_stream_if.source rsp_channel
);

   localparam int PG_W  = $clog2(PAGE_COUNT);
   localparam int RAW_W = VA_W + 1 - OFFSET_WIDTH;
   localparam int TBL_W = PG_W + 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_LOOKUP,
      ST_RESOLVE
   } state_type;

   state_type             state_ff;
   state_type             state_in;
   logic [PG_W-1:0]       clear_addr_ff;
   logic [PG_W-1:0]       clear_addr_in;
   logic [PG_W-1:0]       next_free_ff;
   logic [PG_W-1:0]       next_free_in;
   logic [OFFSET_WIDTH-1:0] offset_ff;
   rsp_payload_type       rsp_payload_ff;
   rsp_payload_type       rsp_payload_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   logic                  req_accept;
   logic                  commit;
   logic [VA_W:0]         va_ext;
   logic [RAW_W-1:0]      raw_page;
   logic [PG_W-1:0]       page;

   cell_ctrl_type         cell_ctrl;
   logic [PG_W-1:0]       cell_tag   [TLB_ENTRIES];
   logic [PG_W-1:0]       cell_frame [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] cell_valid;
   logic [TLB_ENTRIES-1:0] match_vec;
   logic [PG_W-1:0]       match_frame [TLB_ENTRIES];
   logic                  hit_any;
   logic [PG_W-1:0]       hit_frame;

   logic                  tbl_wr_en;
   logic [PG_W-1:0]       tbl_wr_addr;
   logic [TBL_W-1:0]      tbl_wr_data;
   logic [TBL_W-1:0]      tbl_rd_data;
   logic                  tbl_valid;
   logic [PG_W-1:0]       tbl_frame;

   logic                  fault_sel;
   logic [PG_W-1:0]       frame_sel;
   logic [PG_W-1:0]       next_free_inc;

   assign req_accept        = req_channel.valid && req_channel.ready;
   assign req_channel.ready = (state_ff == ST_IDLE);

   assign va_ext   = {1'b0, req_channel.payload.virtual_address};
   assign raw_page = RAW_W'(va_ext >> OFFSET_WIDTH);

   tlbpt_reduce #(
      .RAW_W      (RAW_W),
      .PAGE_COUNT (PAGE_COUNT)
   ) u_reduce (
      .clock    (clock),
      .load     (req_accept),
      .raw_page (raw_page),
      .advance  (state_ff == ST_REDUCE),
      .page     (page)
   );

   // TLB cell row
   assign cell_ctrl.capture = (state_ff == ST_LOOKUP);
   assign cell_ctrl.shift   = commit && !hit_any;

   for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
      logic [PG_W-1:0] feed_tag;
      logic [PG_W-1:0] feed_frame;
      logic            feed_valid;

      if (i == 0) begin : g_head
         assign feed_tag   = page;
         assign feed_frame = frame_sel;
         assign feed_valid = 1'b1;
      end else begin : g_body
         assign feed_tag   = cell_tag[i-1];
         assign feed_frame = cell_frame[i-1];
         assign feed_valid = cell_valid[i-1];
      end

      tlbpt_cell #(
         .PAGE_W (PG_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .lookup_page (page),
         .in_tag      (feed_tag),
         .in_frame    (feed_frame),
         .in_valid    (feed_valid),
         .out_tag     (cell_tag[i]),
         .out_frame   (cell_frame[i]),
         .out_valid   (cell_valid[i]),
         .match       (match_vec[i]),
         .match_frame (match_frame[i])
      );
   end

   assign hit_any = |match_vec;

   always_comb begin
      hit_frame = '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         hit_frame = hit_frame | match_frame[i];
      end
   end

   // page table: {valid, frame}
   tlbpt_ram #(
      .WIDTH (TBL_W),
      .DEPTH (PAGE_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (state_ff == ST_LOOKUP),
      .rd_addr (page),
      .rd_data (tbl_rd_data)
   );

   assign tbl_valid = tbl_rd_data[TBL_W-1];
   assign tbl_frame = tbl_rd_data[PG_W-1:0];

   assign fault_sel = !hit_any && !tbl_valid;
   assign frame_sel = hit_any ? hit_frame : (tbl_valid ? tbl_frame : next_free_ff);

   assign next_free_inc = (next_free_ff == PG_W'(PAGE_COUNT - 1)) ? '0
                                                                  : next_free_ff + 1'b1;

   assign tbl_wr_en   = (state_ff == ST_CLEAR) || (commit && fault_sel);
   assign tbl_wr_addr = (state_ff == ST_CLEAR) ? clear_addr_ff : page;
   assign tbl_wr_data = (state_ff == ST_CLEAR) ? '0 : {1'b1, next_free_ff};

   assign commit = (state_ff == ST_RESOLVE) && (!rsp_valid_ff || rsp_channel.ready);

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == PG_W'(PAGE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE:  state_in = ST_LOOKUP;
         ST_LOOKUP:  state_in = ST_RESOLVE;
         ST_RESOLVE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      next_free_in   = (commit && fault_sel) ? next_free_inc : next_free_ff;
      rsp_valid_in   = commit || (rsp_valid_ff && !rsp_channel.ready);
      rsp_payload_in = rsp_payload_ff;
      if (commit) begin
         rsp_payload_in.phys_addr  = PA_W'({frame_sel, offset_ff});
         rsp_payload_in.tlb_hit    = hit_any;
         rsp_payload_in.page_fault = fault_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         next_free_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         next_free_ff  <= next_free_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
      if (req_accept) begin
         offset_ff <= req_channel.payload.virtual_address[OFFSET_WIDTH-1:0];
      end
   end

   assign rsp_channel.valid   = rsp_valid_ff;
   assign rsp_channel.payload = rsp_payload_ff;

   // a page is only pushed on a miss, so no two live entries share a tag
   `TLBPT_ASSERT_HOLDS(a_single_match, clock, reset, state_ff == ST_RESOLVE, $onehot0(match_vec), "several TLB cells matched")
   `TLBPT_ASSERT_HOLDS(a_hit_no_fault, clock, reset, rsp_valid_ff, !(rsp_payload_ff.tlb_hit && rsp_payload_ff.page_fault), "hit and fault both set")
   `TLBPT_ASSERT_NEXT(a_fill_head, clock, reset, cell_ctrl.shift, cell_valid[0] && cell_tag[0] == $past(page) && cell_frame[0] == $past(frame_sel), "TLB fill lost")
   `TLBPT_ASSERT_NEXT(a_frame_alloc, clock, reset, commit && fault_sel, next_free_ff == (($past(next_free_ff) == PG_W'(PAGE_COUNT - 1)) ? '0 : $past(next_free_ff) + 1'b1), "frame allocation skipped")

endmodule
